// ===== hw/rtl/hws_pkg.sv =====
`default_nettype none
package hws_pkg;

    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;

    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [15:0] WAVE_SPEED_RST = 16'd4096;
    localparam logic [15:0] DAMPING_RST    = 16'd65208;

    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_WRITE = 2'd1,
        FN_READ  = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [0:0] {
        CFG_WAVE_SPEED = 1'b0,
        CFG_DAMPING    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

    function automatic logic signed [15:0] sat16(input logic signed [MUL_P_W-1:0] x);
        logic signed [15:0] y;
        if (x > MUL_P_W'(32767)) begin
            y = 16'sh7fff;
        end else if (x < -MUL_P_W'(32768)) begin
            y = 16'sh8000;
        end else begin
            y = x[15:0];
        end
        return y;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hws_ram.sv =====
`default_nettype none
module hws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hws_mul.sv =====
`default_nettype none
module hws_mul (
    input  wire logic                                  i_clk,
    input  wire hws_pkg::t_mul_req                     i_req,
    input  wire logic                                  i_sh24,
    output logic signed [hws_pkg::MUL_P_W-1:0]         o_prod,
    output logic signed [hws_pkg::MUL_P_W-1:0]         o_rnd
);

    logic signed [hws_pkg::MUL_P_W-1:0] r_prod;
    logic signed [hws_pkg::MUL_P_W-1:0] w_sum;

    always_ff @(posedge i_clk) begin
        r_prod <= hws_pkg::MUL_P_W'(i_req.a) * hws_pkg::MUL_P_W'(i_req.b);
    end

    always_comb begin
        if (i_sh24) begin
            w_sum = r_prod + (hws_pkg::MUL_P_W'(1) <<< 23);
            o_rnd = w_sum >>> 24;
        end else begin
            w_sum = r_prod + (hws_pkg::MUL_P_W'(1) <<< 15);
            o_rnd = w_sum >>> 16;
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ===== hw/rtl/heightfield_wave_step.sv =====
// Tick: cells are processed one after another, sharing one multiplier and the single read
//   ports of the height and velocity memories; one request at a time.
// Read goes through a registered memory read.
// Result register frees the output side; a new request is taken once it is empty.
// Reset (synchronous, active low) starts a clearing pass over every cell of the first
//   height bank and the velocities; config writes are taken during it.
`default_nettype none
module heightfield_wave_step #(
    parameter int GRID_COLS = hws_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = hws_pkg::GRID_ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_dt,
    input  wire logic [5:0]  i_col,
    input  wire logic [5:0]  i_row,
    input  wire logic signed [15:0] i_new_height,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [15:0] o_read_height
);

    localparam int N  = GRID_COLS * GRID_ROWS;
    localparam int AW = $clog2(N);
    localparam int CW = $clog2(GRID_COLS);
    localparam int RW = $clog2(GRID_ROWS);
    localparam int PW = hws_pkg::MUL_P_W;
    localparam int AMW = hws_pkg::MUL_A_W;
    localparam int BMW = hws_pkg::MUL_B_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RDW   = 6'b000100,
        S_C2A   = 6'b001000,
        S_C2B   = 6'b010000,
        S_TICK  = 6'b100000
    } t_state;

    t_state r_state;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [3:0] r_ph;
    logic r_sel;
    logic [15:0] r_ws;
    logic [15:0] r_damp;
    logic [15:0] r_dt;
    logic [31:0] r_c2;
    logic r_inside;
    logic signed [15:0] r_u;
    logic signed [15:0] r_v;
    logic signed [17:0] r_sum;
    logic signed [18:0] r_lap;
    logic signed [AMW-1:0] r_f;
    logic signed [AMW-1:0] r_vp;
    logic signed [15:0] r_vn;
    logic r_out_valid;
    logic signed [15:0] r_out_data;

    logic w_accept;
    logic w_inside;
    logic [AW-1:0] w_item_idx;
    logic w_item_wr;
    logic w_tick_wr;
    logic w_last;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_waddr;
    logic [15:0] w_hwdata;
    logic h0_we;
    logic h1_we;
    logic v_we;
    logic [15:0] w_vwdata;
    logic [15:0] h0_q;
    logic [15:0] h1_q;
    logic [15:0] v_q;
    logic signed [15:0] w_hrd;
    logic signed [15:0] w_nh;
    hws_pkg::t_mul_req w_req;
    logic w_sh24;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_rnd;

    assign o_in_stall  = !(r_state == S_IDLE && !r_out_valid);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_inside    = (32'(i_col) < GRID_COLS) && (32'(i_row) < GRID_ROWS);
    assign w_item_idx  = AW'(int'(i_row) * GRID_COLS + int'(i_col));
    assign w_item_wr   = w_accept && i_func == hws_pkg::FN_WRITE && w_inside;
    assign w_tick_wr   = r_state == S_TICK && r_ph == 4'd13;
    assign w_last      = r_idx == AW'(N - 1);
    assign w_hrd       = r_sel ? h1_q : h0_q;
    assign w_nh        = hws_pkg::sat16(PW'(r_u) + w_rnd);
    assign w_sh24      = r_ph == 4'd7;

    always_comb begin
        w_raddr = r_idx;
        if (r_state == S_IDLE) begin
            w_raddr = w_item_idx;
        end else begin
            case (r_ph)
                4'd1: w_raddr = (r_col == '0) ? r_idx : r_idx - AW'(1);
                4'd2: w_raddr = (r_col == CW'(GRID_COLS - 1)) ? r_idx : r_idx + AW'(1);
                4'd3: w_raddr = (r_row == '0) ? r_idx : r_idx - AW'(GRID_COLS);
                4'd4: w_raddr = (r_row == RW'(GRID_ROWS - 1)) ? r_idx : r_idx + AW'(GRID_COLS);
                default: w_raddr = r_idx;
            endcase
        end
    end

    always_comb begin
        w_req.a = '0;
        w_req.b = '0;
        if (r_state == S_C2A) begin
            w_req.a = $signed(AMW'(r_ws));
            w_req.b = $signed(BMW'(r_ws));
        end else begin
            case (r_ph)
                4'd6: begin
                    w_req.a = AMW'(r_lap);
                    w_req.b = $signed({1'b0, r_c2});
                end
                4'd8: begin
                    w_req.a = r_f;
                    w_req.b = $signed(BMW'(r_dt));
                end
                4'd10: begin
                    w_req.a = r_vp;
                    w_req.b = $signed(BMW'(r_damp));
                end
                4'd12: begin
                    w_req.a = AMW'(r_vn);
                    w_req.b = $signed(BMW'(r_dt));
                end
                default: begin
                    w_req.a = '0;
                    w_req.b = '0;
                end
            endcase
        end
    end

    assign w_waddr  = w_item_wr ? w_item_idx : r_idx;
    assign w_hwdata = (r_state == S_CLEAR) ? 16'd0 : (w_item_wr ? i_new_height : w_nh);
    assign h0_we    = r_state == S_CLEAR || (w_item_wr && !r_sel) || (w_tick_wr && r_sel);
    assign h1_we    = (w_item_wr && r_sel) || (w_tick_wr && !r_sel);
    assign v_we     = r_state == S_CLEAR || w_tick_wr;
    assign w_vwdata = (r_state == S_CLEAR) ? 16'd0 : r_vn;

    hws_ram #(.WIDTH(16), .DEPTH(N)) u_h0 (
        .i_clk(i_clk), .i_we(h0_we), .i_waddr(w_waddr), .i_wdata(w_hwdata),
        .i_raddr(w_raddr), .o_rdata(h0_q)
    );

    hws_ram #(.WIDTH(16), .DEPTH(N)) u_h1 (
        .i_clk(i_clk), .i_we(h1_we), .i_waddr(w_waddr), .i_wdata(w_hwdata),
        .i_raddr(w_raddr), .o_rdata(h1_q)
    );

    hws_ram #(.WIDTH(16), .DEPTH(N)) u_vel (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(r_idx), .i_wdata(w_vwdata),
        .i_raddr(r_idx), .o_rdata(v_q)
    );

    hws_mul u_mul (
        .i_clk(i_clk), .i_req(w_req), .i_sh24(w_sh24), .o_prod(w_prod), .o_rnd(w_rnd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws   <= hws_pkg::WAVE_SPEED_RST;
            r_damp <= hws_pkg::DAMPING_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hws_pkg::CFG_WAVE_SPEED: r_ws   <= i_cfg_data;
                hws_pkg::CFG_DAMPING:    r_damp <= i_cfg_data;
                default: r_ws <= r_ws;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_ph        <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_idx <= w_last ? '0 : r_idx + AW'(1);
                    if (w_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_dt     <= i_dt;
                        r_inside <= w_inside;
                        case (i_func)
                            hws_pkg::FN_TICK: begin
                                r_state <= S_C2A;
                                r_idx   <= '0;
                                r_col   <= '0;
                                r_row   <= '0;
                                r_ph    <= '0;
                            end
                            hws_pkg::FN_READ: r_state <= S_RDW;
                            default: begin
                                r_out_valid <= 1'b1;
                                r_out_data  <= 16'sd0;
                            end
                        endcase
                    end
                end
                S_RDW: begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= r_inside ? w_hrd : 16'sd0;
                    r_state     <= S_IDLE;
                end
                S_C2A: r_state <= S_C2B;
                S_C2B: begin
                    r_c2    <= w_prod[31:0];
                    r_state <= S_TICK;
                end
                S_TICK: begin
                    r_ph <= (r_ph == 4'd13) ? 4'd0 : r_ph + 4'd1;
                    case (r_ph)
                        4'd1: begin
                            r_u <= w_hrd;
                            r_v <= $signed(v_q);
                        end
                        4'd2: r_sum <= 18'(w_hrd);
                        4'd3: r_sum <= r_sum + 18'(w_hrd);
                        4'd4: r_sum <= r_sum + 18'(w_hrd);
                        4'd5: r_lap <= 19'(r_sum) + 19'(w_hrd) - (19'(r_u) <<< 2);
                        4'd7: r_f <= $signed(w_rnd[AMW-1:0]);
                        4'd9: r_vp <= AMW'(r_v) + $signed(w_rnd[AMW-1:0]);
                        4'd11: r_vn <= hws_pkg::sat16(w_rnd);
                        4'd13: begin
                            if (w_last) begin
                                r_sel       <= !r_sel;
                                r_state     <= S_IDLE;
                                r_out_valid <= 1'b1;
                                r_out_data  <= 16'sd0;
                            end else begin
                                r_idx <= r_idx + AW'(1);
                                if (r_col == CW'(GRID_COLS - 1)) begin
                                    r_col <= '0;
                                    r_row <= r_row + RW'(1);
                                end else begin
                                    r_col <= r_col + CW'(1);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_height = r_out_data;

`ifndef SYNTHESIS
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("request taken while busy");
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result during clearing pass");
    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |-> !((r_sel && h1_we) || (!r_sel && h0_we)))
        else $error("tick wrote the bank it reads");
    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && r_ph == 4'd13 && w_last) |=> (r_sel != $past(r_sel)))
        else $error("bank not swapped at end of tick");
`endif

endmodule
`default_nettype wire
